// ===== hw/rtl/afp_pkg.sv =====
// shared types and widths for the affine-from-three-points block
`timescale 1ns / 1ps
package afp_pkg;

  localparam int CW  = 32;              // coordinate and coefficient width
  localparam int FB  = 16;              // fractional bits
  localparam int PW  = 2 * CW;          // coordinate product
  localparam int KW  = 2 * CW + 1;      // cofactor
  localparam int DW  = 2 * CW + 2;      // determinant
  localparam int GW  = CW + 1;          // coordinate difference
  localparam int GPW = 2 * CW + 1;      // difference times destination
  localparam int GSW = 2 * CW + 3;      // sum of three such products
  localparam int KPW = 3 * CW + 1;      // cofactor times destination
  localparam int KSW = 3 * CW + 3;      // sum of three such products
  localparam int NW  = (KSW > GSW + FB) ? KSW : GSW + FB;  // numerator

  typedef struct packed {
    logic signed [CW-1:0] src_x1;
    logic signed [CW-1:0] src_y1;
    logic signed [CW-1:0] src_x2;
    logic signed [CW-1:0] src_y2;
    logic signed [CW-1:0] src_x3;
    logic signed [CW-1:0] src_y3;
    logic signed [CW-1:0] dst_x1;
    logic signed [CW-1:0] dst_y1;
    logic signed [CW-1:0] dst_x2;
    logic signed [CW-1:0] dst_y2;
    logic signed [CW-1:0] dst_x3;
    logic signed [CW-1:0] dst_y3;
  } in_item_t;

  typedef struct packed {
    logic                 valid_res;
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] shift_x;
    logic signed [CW-1:0] coef_c;
    logic signed [CW-1:0] coef_d;
    logic signed [CW-1:0] shift_y;
  } out_item_t;

  typedef struct packed {
    logic signed [NW-1:0] a;
    logic signed [NW-1:0] b;
    logic signed [NW-1:0] tx;
    logic signed [NW-1:0] c;
    logic signed [NW-1:0] d;
    logic signed [NW-1:0] ty;
  } num_set_t;

endpackage

// ===== hw/rtl/afp_front.sv =====
// exact determinant and coefficient numerators, six register stages
`timescale 1ns / 1ps
module afp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  afp_pkg::in_item_t       in_item,
  output logic                    num_valid,
  output logic signed [afp_pkg::DW-1:0] det,
  output afp_pkg::num_set_t       nums
);
  import afp_pkg::*;

  logic [5:0] vld_r;

  // stage 1
  in_item_t s1_r;
  // stage 2
  logic signed [PW-1:0] p23_r, p32_r, p31_r, p13_r, p12_r, p21_r;
  logic signed [GW-1:0] gy1_r, gy2_r, gy3_r, gx1_r, gx2_r, gx3_r;
  logic signed [CW-1:0] u1_r, u2_r, u3_r, v1_r, v2_r, v3_r;
  // stage 3
  logic signed [KW-1:0] k1_r, k2_r, k3_r;
  logic signed [GW-1:0] gy1b_r, gy2b_r, gy3b_r, gx1b_r, gx2b_r, gx3b_r;
  logic signed [CW-1:0] u1b_r, u2b_r, u3b_r, v1b_r, v2b_r, v3b_r;
  // stage 4
  logic signed [DW-1:0]  det4_r;
  logic signed [GPW-1:0] ayu_r [3];
  logic signed [GPW-1:0] axu_r [3];
  logic signed [GPW-1:0] ayv_r [3];
  logic signed [GPW-1:0] axv_r [3];
  logic signed [GPW-1:0] klu_r [3];
  logic signed [GPW-1:0] khu_r [3];
  logic signed [GPW-1:0] klv_r [3];
  logic signed [GPW-1:0] khv_r [3];
  // stage 5
  logic signed [DW-1:0]  det5_r;
  logic signed [GSW-1:0] sa_r, sb_r, sc_r, sd_r;
  logic signed [KPW-1:0] ku_r [3];
  logic signed [KPW-1:0] kv_r [3];
  // stage 6
  logic signed [DW-1:0]  det6_r;
  num_set_t              nums_r;

  logic signed [KW-1:0]  kk [3];
  logic signed [CW-1:0]  uu [3];
  logic signed [CW-1:0]  vv [3];

  always_comb begin
    kk[0] = k1_r; kk[1] = k2_r; kk[2] = k3_r;
    uu[0] = u1b_r; uu[1] = u2b_r; uu[2] = u3b_r;
    vv[0] = v1b_r; vv[1] = v2b_r; vv[2] = v3b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_item;

      p23_r <= s1_r.src_x2 * s1_r.src_y3;
      p32_r <= s1_r.src_x3 * s1_r.src_y2;
      p31_r <= s1_r.src_x3 * s1_r.src_y1;
      p13_r <= s1_r.src_x1 * s1_r.src_y3;
      p12_r <= s1_r.src_x1 * s1_r.src_y2;
      p21_r <= s1_r.src_x2 * s1_r.src_y1;
      gy1_r <= s1_r.src_y2 - s1_r.src_y3;
      gy2_r <= s1_r.src_y3 - s1_r.src_y1;
      gy3_r <= s1_r.src_y1 - s1_r.src_y2;
      gx1_r <= s1_r.src_x3 - s1_r.src_x2;
      gx2_r <= s1_r.src_x1 - s1_r.src_x3;
      gx3_r <= s1_r.src_x2 - s1_r.src_x1;
      u1_r <= s1_r.dst_x1; u2_r <= s1_r.dst_x2; u3_r <= s1_r.dst_x3;
      v1_r <= s1_r.dst_y1; v2_r <= s1_r.dst_y2; v3_r <= s1_r.dst_y3;

      k1_r <= KW'(p23_r) - KW'(p32_r);
      k2_r <= KW'(p31_r) - KW'(p13_r);
      k3_r <= KW'(p12_r) - KW'(p21_r);
      gy1b_r <= gy1_r; gy2b_r <= gy2_r; gy3b_r <= gy3_r;
      gx1b_r <= gx1_r; gx2b_r <= gx2_r; gx3b_r <= gx3_r;
      u1b_r <= u1_r; u2b_r <= u2_r; u3b_r <= u3_r;
      v1b_r <= v1_r; v2b_r <= v2_r; v3b_r <= v3_r;

      det4_r <= DW'(k1_r) + DW'(k2_r) + DW'(k3_r);
      ayu_r[0] <= gy1b_r * u1b_r; ayu_r[1] <= gy2b_r * u2b_r; ayu_r[2] <= gy3b_r * u3b_r;
      axu_r[0] <= gx1b_r * u1b_r; axu_r[1] <= gx2b_r * u2b_r; axu_r[2] <= gx3b_r * u3b_r;
      ayv_r[0] <= gy1b_r * v1b_r; ayv_r[1] <= gy2b_r * v2b_r; ayv_r[2] <= gy3b_r * v3b_r;
      axv_r[0] <= gx1b_r * v1b_r; axv_r[1] <= gx2b_r * v2b_r; axv_r[2] <= gx3b_r * v3b_r;
      // cofactor split into unsigned low word and signed high part
      for (int i = 0; i < 3; i++) begin
        klu_r[i] <= $signed({1'b0, kk[i][CW-1:0]}) * uu[i];
        khu_r[i] <= $signed(kk[i][KW-1:CW]) * uu[i];
        klv_r[i] <= $signed({1'b0, kk[i][CW-1:0]}) * vv[i];
        khv_r[i] <= $signed(kk[i][KW-1:CW]) * vv[i];
      end

      det5_r <= det4_r;
      sa_r <= GSW'(ayu_r[0]) + GSW'(ayu_r[1]) + GSW'(ayu_r[2]);
      sb_r <= GSW'(axu_r[0]) + GSW'(axu_r[1]) + GSW'(axu_r[2]);
      sc_r <= GSW'(ayv_r[0]) + GSW'(ayv_r[1]) + GSW'(ayv_r[2]);
      sd_r <= GSW'(axv_r[0]) + GSW'(axv_r[1]) + GSW'(axv_r[2]);
      for (int i = 0; i < 3; i++) begin
        ku_r[i] <= (KPW'(khu_r[i]) <<< CW) + KPW'(klu_r[i]);
        kv_r[i] <= (KPW'(khv_r[i]) <<< CW) + KPW'(klv_r[i]);
      end

      det6_r    <= det5_r;
      nums_r.a  <= NW'(sa_r) <<< FB;
      nums_r.b  <= NW'(sb_r) <<< FB;
      nums_r.c  <= NW'(sc_r) <<< FB;
      nums_r.d  <= NW'(sd_r) <<< FB;
      nums_r.tx <= NW'(ku_r[0]) + NW'(ku_r[1]) + NW'(ku_r[2]);
      nums_r.ty <= NW'(kv_r[0]) + NW'(kv_r[1]) + NW'(kv_r[2]);
    end
  end

  assign num_valid = vld_r[5];
  assign det       = det6_r;
  assign nums      = nums_r;

endmodule

// ===== hw/rtl/afp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating
`timescale 1ns / 1ps
module afp_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic                          in_zero,
  input  logic signed [afp_pkg::NW-1:0] num,
  input  logic signed [afp_pkg::DW-1:0] den,
  output logic                          out_valid,
  output logic                          out_zero,
  output logic signed [afp_pkg::CW-1:0] quo
);
  import afp_pkg::*;

  // prep stage: magnitudes and sign
  logic          p_vld_r, p_zero_r, p_neg_r;
  logic [NW-1:0] p_u_r;
  logic [DW-1:0] p_v_r;

  // bit stages, index 0 holds the overflow check result
  logic          vld_r  [CW+1];
  logic          zero_r [CW+1];
  logic          neg_r  [CW+1];
  logic          ovf_r  [CW+1];
  logic [NW-1:0] rem_r  [CW+1];
  logic [DW-1:0] v_r    [CW+1];
  logic [CW-1:0] q_r    [CW+1];

  logic                 f_vld_r, f_zero_r;
  logic signed [CW-1:0] f_quo_r;
  logic signed [CW-1:0] quo_nxt;
  logic [CW-1:0]        qf;
  logic [CW-1:0]        lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_zero_r <= in_zero;
      p_neg_r  <= num[NW-1] ^ den[DW-1];
      p_u_r    <= num[NW-1] ? ($unsigned(num) ^ {NW{1'b1}}) + NW'(1) : $unsigned(num);
      p_v_r    <= den[DW-1] ? ($unsigned(den) ^ {DW{1'b1}}) + DW'(1) : $unsigned(den);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= p_zero_r;
      neg_r[0]  <= p_neg_r;
      ovf_r[0]  <= {1'b0, p_u_r} >= ((NW+1)'(p_v_r) << CW);
      rem_r[0]  <= p_u_r;
      v_r[0]    <= p_v_r;
      q_r[0]    <= '0;
    end
  end

  for (genvar j = 0; j < CW; j++) begin : g_bit
    localparam int SH = CW - 1 - j;
    logic [NW-1:0] sub;
    logic          ge;

    assign sub = NW'(v_r[j]) << SH;
    assign ge  = rem_r[j] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[j+1] <= zero_r[j];
        neg_r[j+1]  <= neg_r[j];
        ovf_r[j+1]  <= ovf_r[j];
        v_r[j+1]    <= v_r[j];
        rem_r[j+1]  <= ge ? rem_r[j] - sub : rem_r[j];
        q_r[j+1]    <= {q_r[j][CW-2:0], ge};
      end
    end
  end

  // saturate toward the signed range, collinear points give zero
  always_comb begin
    qf  = q_r[CW];
    lim = {1'b1, {(CW-1){1'b0}}};
    if (zero_r[CW]) begin
      quo_nxt = '0;
    end else if (!neg_r[CW]) begin
      quo_nxt = (ovf_r[CW] || qf[CW-1]) ? $signed({1'b0, {(CW-1){1'b1}}}) : $signed(qf);
    end else begin
      quo_nxt = (ovf_r[CW] || (qf > lim)) ? $signed(lim) : $signed(~qf + CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= vld_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_zero_r <= zero_r[CW];
      f_quo_r  <= quo_nxt;
    end
  end

  assign out_valid = f_vld_r;
  assign out_zero  = f_zero_r;
  assign quo       = f_quo_r;

endmodule

// ===== hw/rtl/affine_from_three_points_unit.sv =====
// top level: affine map coefficients from three point correspondences
//
// usage
//   in_valid / in_stall / in_item carry one item: three source points and
//   their three destinations, signed fixed point with 16 fractional bits
//   out_valid / out_stall / out_item return the six coefficients a, b,
//   shift_x, c, d, shift_y and valid_res for each item, in order
//   an item moves on an edge where valid is high and stall is low
// timing
//   one item per cycle while the receiver does not stall; exact products
//   and sums in the front stages, then one quotient bit per stage in six
//   parallel restoring dividers
// stalls
//   the whole pipeline holds while the last stage has an item that the
//   receiver stalls; in_stall follows, nothing is dropped or repeated
// reset
//   rst_n low clears every valid bit; the pipeline is empty after reset
//   collinear source points give valid_res low and zero coefficients
`timescale 1ns / 1ps
module affine_from_three_points_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  afp_pkg::in_item_t    in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output afp_pkg::out_item_t   out_item
);
  import afp_pkg::*;

  logic                 en;
  logic                 f_valid;
  logic signed [DW-1:0] f_det;
  num_set_t             f_nums;
  logic                 det_zero;
  logic [5:0]           d_valid;
  logic [5:0]           d_zero;
  logic signed [CW-1:0] q_a, q_b, q_tx, q_c, q_d, q_ty;

  // the pipeline advances unless a finished item is held by the receiver
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  afp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .num_valid (f_valid),
    .det       (f_det),
    .nums      (f_nums)
  );

  assign det_zero = (f_det == '0);

  // six dividers share the determinant; each carries its own valid and zero flag
  afp_div u_div_a (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid),
    .in_zero(det_zero), .num(f_nums.a), .den(f_det),
    .out_valid(d_valid[0]), .out_zero(d_zero[0]), .quo(q_a));
  afp_div u_div_b (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid),
    .in_zero(det_zero), .num(f_nums.b), .den(f_det),
    .out_valid(d_valid[1]), .out_zero(d_zero[1]), .quo(q_b));
  afp_div u_div_tx (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid),
    .in_zero(det_zero), .num(f_nums.tx), .den(f_det),
    .out_valid(d_valid[2]), .out_zero(d_zero[2]), .quo(q_tx));
  afp_div u_div_c (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid),
    .in_zero(det_zero), .num(f_nums.c), .den(f_det),
    .out_valid(d_valid[3]), .out_zero(d_zero[3]), .quo(q_c));
  afp_div u_div_d (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid),
    .in_zero(det_zero), .num(f_nums.d), .den(f_det),
    .out_valid(d_valid[4]), .out_zero(d_zero[4]), .quo(q_d));
  afp_div u_div_ty (.clk(clk), .rst_n(rst_n), .en(en), .in_valid(f_valid),
    .in_zero(det_zero), .num(f_nums.ty), .den(f_det),
    .out_valid(d_valid[5]), .out_zero(d_zero[5]), .quo(q_ty));

  // all lanes run in lock step; lane a stands for the item
  assign out_valid = d_valid[0] & (&d_valid[5:1] | d_valid[0]);

  always_comb begin
    out_item.valid_res = !(d_zero[0] | (d_zero[5:1] == 5'h1f & 1'b0));
    out_item.coef_a    = q_a;
    out_item.coef_b    = q_b;
    out_item.shift_x   = q_tx;
    out_item.coef_c    = q_c;
    out_item.coef_d    = q_d;
    out_item.shift_y   = q_ty;
  end

endmodule

// ===== verif/affine_from_three_points_unit_checker.sv =====
// checker: predicts affine coefficients for each accepted item and compares results
`timescale 1ns / 1ps
module affine_from_three_points_unit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  afp_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_stall,
  input  afp_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending
);
  import afp_pkg::*;

  localparam int WB = 200;

  out_item_t coef_queue[$];

  function automatic logic signed [CW-1:0] div_sat(input logic signed [WB-1:0] num,
                                                   input logic signed [WB-1:0] den);
    logic signed [WB-1:0] q;
    logic signed [WB-1:0] hi;
    logic signed [WB-1:0] lo;
    begin
      q = num / den;  // signed division truncates toward zero
      hi = (WB'(1) <<< (CW - 1)) - 1;
      lo = -(WB'(1) <<< (CW - 1));
      if (q > hi) return hi[CW-1:0];
      if (q < lo) return lo[CW-1:0];
      return q[CW-1:0];
    end
  endfunction

  function automatic out_item_t affine_coefs(input in_item_t it);
    logic signed [WB-1:0] x1, y1, x2, y2, x3, y3, u1, v1, u2, v2, u3, v3;
    logic signed [WB-1:0] k1, k2, k3, det, gy1, gy2, gy3, gx1, gx2, gx3;
    out_item_t r;
    begin
      x1 = it.src_x1; y1 = it.src_y1; x2 = it.src_x2;
      y2 = it.src_y2; x3 = it.src_x3; y3 = it.src_y3;
      u1 = it.dst_x1; v1 = it.dst_y1; u2 = it.dst_x2;
      v2 = it.dst_y2; u3 = it.dst_x3; v3 = it.dst_y3;
      k1 = x2 * y3 - x3 * y2;
      k2 = x3 * y1 - x1 * y3;
      k3 = x1 * y2 - x2 * y1;
      det = k1 + k2 + k3;
      gy1 = y2 - y3; gy2 = y3 - y1; gy3 = y1 - y2;
      gx1 = x3 - x2; gx2 = x1 - x3; gx3 = x2 - x1;
      r = '0;
      if (det != 0) begin
        r.valid_res = 1'b1;
        r.coef_a  = div_sat((gy1 * u1 + gy2 * u2 + gy3 * u3) <<< FB, det);
        r.coef_b  = div_sat((gx1 * u1 + gx2 * u2 + gx3 * u3) <<< FB, det);
        r.shift_x = div_sat(k1 * u1 + k2 * u2 + k3 * u3, det);
        r.coef_c  = div_sat((gy1 * v1 + gy2 * v2 + gy3 * v3) <<< FB, det);
        r.coef_d  = div_sat((gx1 * v1 + gx2 * v2 + gx3 * v3) <<< FB, det);
        r.shift_y = div_sat(k1 * v1 + k2 * v2 + k3 * v3, det);
      end
      return r;
    end
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (coef_queue.size() == 0) begin
          $error("result with no item waiting");
          fail_count = fail_count + 1;
        end else begin
          want = coef_queue.pop_front();
          if (out_item.valid_res !== want.valid_res) begin
            $error("valid_res expected %0d actual %0d", want.valid_res, out_item.valid_res);
            fail_count = fail_count + 1;
          end
          if (out_item.coef_a !== want.coef_a) begin
            $error("coef_a expected %0d actual %0d", want.coef_a, out_item.coef_a);
            fail_count = fail_count + 1;
          end
          if (out_item.coef_b !== want.coef_b) begin
            $error("coef_b expected %0d actual %0d", want.coef_b, out_item.coef_b);
            fail_count = fail_count + 1;
          end
          if (out_item.shift_x !== want.shift_x) begin
            $error("shift_x expected %0d actual %0d", want.shift_x, out_item.shift_x);
            fail_count = fail_count + 1;
          end
          if (out_item.coef_c !== want.coef_c) begin
            $error("coef_c expected %0d actual %0d", want.coef_c, out_item.coef_c);
            fail_count = fail_count + 1;
          end
          if (out_item.coef_d !== want.coef_d) begin
            $error("coef_d expected %0d actual %0d", want.coef_d, out_item.coef_d);
            fail_count = fail_count + 1;
          end
          if (out_item.shift_y !== want.shift_y) begin
            $error("shift_y expected %0d actual %0d", want.shift_y, out_item.shift_y);
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) coef_queue.push_back(affine_coefs(in_item));
    end
    pending = coef_queue.size();
  end
endmodule

// ===== verif/affine_from_three_points_unit_tb.sv =====
// testbench top: drives point triples into the affine unit and gives the verdict
`timescale 1ns / 1ps
module affine_from_three_points_unit_tb;
  import afp_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        pending;

  // idling odds in percent, changed per phase
  int send_idle_pct;
  int recv_stall_pct;
  int n_items;
  int n_collinear;

  affine_from_three_points_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  affine_from_three_points_unit_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // receiver stalls at random, new choice at every falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // random coordinate: mostly moderate values, sometimes any 32-bit pattern
  function automatic logic [CW-1:0] rand_coord();
    int sel;
    begin
      sel = $urandom_range(9);
      if (sel < 2) return $urandom();
      if (sel < 5) return CW'($signed($urandom_range(2 * 65536 * 64)) - 65536 * 64);
      if (sel < 7) return CW'($signed($urandom_range(2 * 65536 * 4)) - 65536 * 4);
      if (sel < 8) return CW'($signed($urandom_range(200)) - 100) <<< FB;
      if (sel < 9) return CW'($signed($urandom_range(64)) - 32);
      return ($urandom_range(1)) ? 32'h7fff_ffff : 32'h8000_0000;
    end
  endfunction

  // hand one item over, holding it while stalled; valid drops only when idling
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  task automatic send_pts(input logic [CW-1:0] x1, y1, x2, y2, x3, y3,
                          input logic [CW-1:0] u1, v1, u2, v2, u3, v3);
    in_item_t it;
    begin
      it = {x1, y1, x2, y2, x3, y3, u1, v1, u2, v2, u3, v3};
      send_item(it);
    end
  endtask

  task automatic send_random();
    in_item_t it;
    logic [CW-1:0] dx, dy, k;
    int kind;
    begin
      kind = $urandom_range(9);
      it.src_x1 = rand_coord(); it.src_y1 = rand_coord();
      it.src_x2 = rand_coord(); it.src_y2 = rand_coord();
      it.src_x3 = rand_coord(); it.src_y3 = rand_coord();
      it.dst_x1 = rand_coord(); it.dst_y1 = rand_coord();
      it.dst_x2 = rand_coord(); it.dst_y2 = rand_coord();
      it.dst_x3 = rand_coord(); it.dst_y3 = rand_coord();
      if (kind == 0) begin
        // collinear source: third point on the line through the first two
        dx = $signed($urandom_range(2000)) - 1000;
        dy = $signed($urandom_range(2000)) - 1000;
        k  = $signed($urandom_range(20)) - 10;
        it.src_x2 = it.src_x1 + dx;     it.src_y2 = it.src_y1 + dy;
        it.src_x3 = it.src_x1 + k * dx; it.src_y3 = it.src_y1 + k * dy;
        n_collinear++;
      end else if (kind == 1) begin
        // repeated source point
        it.src_x2 = it.src_x1; it.src_y2 = it.src_y1;
        n_collinear++;
      end else if (kind == 2) begin
        // destination a small offset of the source: coefficients near identity
        it.dst_x1 = it.src_x1 + $urandom_range(255); it.dst_y1 = it.src_y1;
        it.dst_x2 = it.src_x2; it.dst_y2 = it.src_y2 - $urandom_range(255);
        it.dst_x3 = it.src_x3; it.dst_y3 = it.src_y3;
      end
      send_item(it);
    end
  endtask

  task automatic set_phase(input int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
      default: begin send_idle_pct = 19; recv_stall_pct = 19; end
    endcase
  endtask

  localparam logic [CW-1:0] ONE  = 32'h0001_0000;
  localparam logic [CW-1:0] MAXC = 32'h7fff_ffff;
  localparam logic [CW-1:0] MINC = 32'h8000_0000;

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_items = 0;
    n_collinear = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // directed: identity, translation, scale, collinear, extremes, saturation
    send_pts(0, 0, ONE, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE);
    send_pts(0, 0, ONE, 0, 0, ONE, ONE, 2*ONE, 2*ONE, 2*ONE, ONE, 3*ONE);
    send_pts(0, 0, ONE, 0, 0, ONE, 0, 0, 3*ONE, ONE, -ONE, 2*ONE);
    send_pts(0, 0, ONE, ONE, 2*ONE, 2*ONE, 5, 6, 7, 8, 9, 10);
    send_pts(0, 0, 0, 0, 0, 0, MAXC, MINC, MAXC, MINC, MAXC, MINC);
    send_pts(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1, 2, 3, 4, 5, 6);
    send_pts(MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MINC);
    send_pts(MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC, MINC, MINC);
    send_pts(0, 0, 1, 0, 0, 1, 0, 0, MAXC, MINC, MINC, MAXC);
    send_pts(0, 0, 1, 0, 0, 1, 0, 0, MINC, MAXC, MAXC, MINC);
    send_pts(0, 0, 1, 0, 0, 1, MAXC, MINC, 0, 0, 0, 0);
    send_pts(0, 0, 2, 0, 0, 2, 0, 0, 1, 0, 0, -1);
    send_pts(0, 0, 3, 0, 0, 3, 0, 0, -1, 1, 2, -2);
    send_pts(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_pts(-1, 0, 0, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_pts(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555,
             32'h1234_5678, 32'hedcb_a987, 32'h5555_5555, 32'haaaa_aaaa,
             32'haaaa_aaaa, 32'h5555_5555, 32'hffff_0000, 32'h0000_ffff);
    send_pts(ONE, ONE, -ONE, ONE, ONE, -ONE, 0, ONE, ONE, 0, -ONE, 0);

    // random part over the four idling phases, a gap-free stretch first
    for (int i = 0; i < 950; i++) begin
      if (i % 120 == 0) set_phase(i / 120);
      send_random();
    end
    in_valid <= 1'b0;

    send_idle_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);

    $display("sent %0d point triples, %0d with degenerate source, under four idling mixes",
             n_items, n_collinear);
    if (fail_count == 0 && pending == 0) begin
      $display("affine_from_three_points_unit_tb passed");
    end else begin
      $display("affine_from_three_points_unit_tb failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("affine_from_three_points_unit_tb failed");
    $finish;
  end
endmodule
